// ===== hdl/adsr_pkg.sv =====
package adsr_pkg;

  localparam int unsigned LEN_W     = 24;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 3'd0,
    CFG_DECAY   = 3'd1,
    CFG_RELEASE = 3'd2,
    CFG_START   = 3'd3,
    CFG_SUSTAIN = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SEG_ZERO    = 3'd0,
    SEG_ATTACK  = 3'd1,
    SEG_DEC_UP  = 3'd2,
    SEG_DEC_DN  = 3'd3,
    SEG_SUSTAIN = 3'd4
  } seg_e;

  localparam logic [LEN_W-1:0] ATTACK_RST  = 24'd4410;
  localparam logic [LEN_W-1:0] DECAY_RST   = 24'd4410;
  localparam logic [LEN_W-1:0] RELEASE_RST = 24'd8820;

endpackage

// ===== hdl/adsr_div_cell.sv =====
module adsr_div_cell #(
  parameter int unsigned DW = 24,
  parameter int unsigned QW = 17,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] nq_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] nq_o,
  output logic [DW-1:0] den_o,
  output logic [SW-1:0] side_o
);

  // one restoring step: bring in the next numerator bit, try the subtract
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          take;

  logic          valid_q;
  logic [DW-1:0] rem_q;
  logic [QW-1:0] nq_q;
  logic [DW-1:0] den_q;
  logic [SW-1:0] side_q;

  assign trial = {rem_i, nq_i[QW-1]};
  assign diff  = trial - {1'b0, den_i};
  assign take  = trial >= {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= take ? diff[DW-1:0] : trial[DW-1:0];
    nq_q   <= {nq_i[QW-2:0], take};
    den_q  <= den_i;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

// ===== hdl/adsr_div_chain.sv =====
module adsr_div_chain #(
  parameter int unsigned DW = 24,
  parameter int unsigned QW = 17,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  // one cell per quotient bit; numerator bits leave the top of nq as
  // quotient bits enter at the bottom
  logic          valid_w [QW+1];
  logic [DW-1:0] rem_w   [QW+1];
  logic [QW-1:0] nq_w    [QW+1];
  logic [DW-1:0] den_w   [QW+1];
  logic [SW-1:0] side_w  [QW+1];

  assign valid_w[0] = valid_i;
  assign rem_w[0]   = rem_i;
  assign nq_w[0]    = num_i;
  assign den_w[0]   = den_i;
  assign side_w[0]  = side_i;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    adsr_div_cell #(
      .DW(DW),
      .QW(QW),
      .SW(SW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_w[i]),
      .rem_i  (rem_w[i]),
      .nq_i   (nq_w[i]),
      .den_i  (den_w[i]),
      .side_i (side_w[i]),
      .valid_o(valid_w[i+1]),
      .rem_o  (rem_w[i+1]),
      .nq_o   (nq_w[i+1]),
      .den_o  (den_w[i+1]),
      .side_o (side_w[i+1])
    );
  end

  assign valid_o = valid_w[QW];
  assign quo_o   = nq_w[QW];
  assign side_o  = side_w[QW];

endmodule

// ===== hdl/adsr_envelope_amplitude.sv =====
// ADSR envelope level from now, note-on and note-off ticks. One item is taken
// every clock (busy stays low) and its result appears, once it has passed the
// stage registers and both divider chains, for one cycle with done_o high. The
// receiver cannot stall, so results must be taken as they come. The result passes
// two chains of divider cells, each resolving one quotient bit per cell: the
// first gives the held level, the second the release ramp from it. The user must
// write configuration only while no item is in flight; the block does not enforce it.
module adsr_envelope_amplitude #(
  parameter int unsigned TIME_BITS       = 32,
  parameter int unsigned LEVEL_FRAC_BITS = 16,
  localparam int unsigned LvlW = LEVEL_FRAC_BITS + 1,
  localparam int unsigned CfgW = (LvlW > adsr_pkg::LEN_W) ? LvlW : adsr_pkg::LEN_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [TIME_BITS-1:0]           now_tick_i,
  input  logic [TIME_BITS-1:0]           on_tick_i,
  input  logic [TIME_BITS-1:0]           off_tick_i,
  input  logic                           cfg_we_i,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]                cfg_data_i,
  output logic [LvlW-1:0]                level_o,
  output logic                           silent_o,
  output logic                           done_o
);

  localparam int unsigned LenW   = adsr_pkg::LEN_W;
  localparam int unsigned CmpW   = (TIME_BITS > LenW + 1) ? TIME_BITS : LenW + 1;
  localparam int unsigned MaxW   = (TIME_BITS > LenW) ? TIME_BITS : LenW;
  localparam int unsigned Prod1W = LenW + LvlW;
  localparam int unsigned Prod2W = TIME_BITS + LvlW;
  localparam logic [LvlW-1:0] One = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic                 held;
    logic                 rneg;
    logic                 rbig;
    logic [TIME_BITS-1:0] mag;
    adsr_pkg::seg_e       seg;
  } side1_t;

  typedef struct packed {
    logic held;
    logic rneg;
    logic rbig;
  } flags_t;

  typedef struct packed {
    logic [LvlW-1:0] base;
    flags_t          flags;
    logic            ovf;
  } side2_t;

  localparam int unsigned Side1W = $bits(side1_t);
  localparam int unsigned Side2W = $bits(side2_t);

  // configuration
  logic [LenW-1:0] attack_q, decay_q, release_q;
  logic [LvlW-1:0] start_q, sustain_q;
  logic [LenW-1:0] att_e, dec_e, rel_e;
  logic [LvlW-1:0] st_e, su_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= adsr_pkg::ATTACK_RST;
      decay_q   <= adsr_pkg::DECAY_RST;
      release_q <= adsr_pkg::RELEASE_RST;
      start_q   <= One;
      sustain_q <= One;
    end else if (cfg_we_i) begin
      case (adsr_pkg::cfg_idx_e'(cfg_idx_i))
        adsr_pkg::CFG_ATTACK:  attack_q  <= cfg_data_i[LenW-1:0];
        adsr_pkg::CFG_DECAY:   decay_q   <= cfg_data_i[LenW-1:0];
        adsr_pkg::CFG_RELEASE: release_q <= cfg_data_i[LenW-1:0];
        adsr_pkg::CFG_START:   start_q   <= cfg_data_i[LvlW-1:0];
        adsr_pkg::CFG_SUSTAIN: sustain_q <= cfg_data_i[LvlW-1:0];
        default: ;
      endcase
    end
  end

  assign att_e = (attack_q == '0) ? LenW'(1) : attack_q;
  assign dec_e = (decay_q == '0) ? LenW'(1) : decay_q;
  assign rel_e = (release_q == '0) ? LenW'(1) : release_q;
  assign st_e  = (start_q > One) ? One : start_q;
  assign su_e  = (sustain_q > One) ? One : sustain_q;

  assign busy = 1'b0;

  // stage 1: time differences
  logic                 s1_valid_q;
  logic                 s1_held_q;
  logic [TIME_BITS:0]   s1_life_q, s1_r_q;
  logic                 held_d;

  assign held_d = on_tick_i > off_tick_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_held_q <= held_d;
    s1_life_q <= held_d ? ({1'b0, now_tick_i} - {1'b0, on_tick_i})
                        : ({1'b0, off_tick_i} - {1'b0, on_tick_i});
    s1_r_q    <= {1'b0, now_tick_i} - {1'b0, off_tick_i};
  end

  // stage 2: segment of the held envelope, release distance
  logic [CmpW-1:0]      life_u, dec_off;
  logic                 life_le0, le_att, le_ad;
  logic [TIME_BITS:0]   r_neg;
  adsr_pkg::seg_e       seg_d;
  logic [LenW-1:0]      x_d, den1_d;
  logic [LvlW-1:0]      lv_d;
  side1_t               side1_d;

  assign life_u   = CmpW'(s1_life_q[TIME_BITS-1:0]);
  assign life_le0 = s1_life_q[TIME_BITS] || (s1_life_q == '0);
  assign le_att   = life_u <= CmpW'(att_e);
  assign le_ad    = life_u <= (CmpW'(att_e) + CmpW'(dec_e));
  assign dec_off  = life_u - CmpW'(att_e);
  assign r_neg    = '0 - s1_r_q;

  always_comb begin
    seg_d  = adsr_pkg::SEG_SUSTAIN;
    x_d    = '0;
    lv_d   = '0;
    den1_d = att_e;
    if (life_le0) begin
      seg_d = adsr_pkg::SEG_ZERO;
    end else if (le_att) begin
      seg_d = adsr_pkg::SEG_ATTACK;
      x_d   = life_u[LenW-1:0];
      lv_d  = st_e;
    end else if (le_ad) begin
      x_d    = dec_off[LenW-1:0];
      den1_d = dec_e;
      if (su_e >= st_e) begin
        seg_d = adsr_pkg::SEG_DEC_UP;
        lv_d  = su_e - st_e;
      end else begin
        seg_d = adsr_pkg::SEG_DEC_DN;
        lv_d  = st_e - su_e;
      end
    end
  end

  assign side1_d.held = s1_held_q;
  assign side1_d.rneg = s1_r_q[TIME_BITS];
  assign side1_d.rbig = !s1_r_q[TIME_BITS] &&
                        (CmpW'(s1_r_q[TIME_BITS-1:0]) >= CmpW'(rel_e));
  assign side1_d.mag  = s1_r_q[TIME_BITS] ? r_neg[TIME_BITS-1:0] : s1_r_q[TIME_BITS-1:0];
  assign side1_d.seg  = seg_d;

  logic            s2_valid_q;
  logic [LenW-1:0] s2_x_q, s2_den_q;
  logic [LvlW-1:0] s2_lv_q;
  side1_t          s2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_x_q    <= x_d;
    s2_lv_q   <= lv_d;
    s2_den_q  <= den1_d;
    s2_side_q <= side1_d;
  end

  // stage 3: numerator of the held-level division
  logic              s3_valid_q;
  logic [Prod1W-1:0] s3_prod_q;
  logic [LenW-1:0]   s3_den_q;
  side1_t            s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_prod_q <= Prod1W'(s2_x_q) * Prod1W'(s2_lv_q);
    s3_den_q  <= s2_den_q;
    s3_side_q <= s2_side_q;
  end

  logic              d1_valid;
  logic [LvlW-1:0]   d1_quo;
  logic [Side1W-1:0] d1_side_bits;
  side1_t            d1_side;

  adsr_div_chain #(
    .DW(LenW),
    .QW(LvlW),
    .SW(Side1W)
  ) u_div_held (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s3_valid_q),
    .rem_i  (s3_prod_q[Prod1W-1:LvlW]),
    .num_i  (s3_prod_q[LvlW-1:0]),
    .den_i  (s3_den_q),
    .side_i (s3_side_q),
    .valid_o(d1_valid),
    .quo_o  (d1_quo),
    .side_o (d1_side_bits)
  );

  assign d1_side = side1_t'(d1_side_bits);

  // stage 4: held level, the base of the release ramp
  logic [LvlW-1:0] h_d;

  always_comb begin
    case (d1_side.seg)
      adsr_pkg::SEG_ZERO:   h_d = '0;
      adsr_pkg::SEG_ATTACK: h_d = d1_quo;
      adsr_pkg::SEG_DEC_UP: h_d = st_e + d1_quo;
      adsr_pkg::SEG_DEC_DN: h_d = st_e - d1_quo;
      default:              h_d = su_e;
    endcase
  end

  logic                 s4_valid_q;
  logic [LvlW-1:0]      s4_h_q;
  logic [TIME_BITS-1:0] s4_mag_q;
  flags_t               s4_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= d1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_h_q          <= h_d;
    s4_mag_q        <= d1_side.mag;
    s4_flags_q.held <= d1_side.held;
    s4_flags_q.rneg <= d1_side.rneg;
    s4_flags_q.rbig <= d1_side.rbig;
  end

  // stage 5: numerator of the release division
  logic              s5_valid_q;
  logic [Prod2W-1:0] s5_prod_q;
  logic [LvlW-1:0]   s5_h_q;
  flags_t            s5_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_prod_q  <= Prod2W'(s4_mag_q) * Prod2W'(s4_h_q);
    s5_h_q     <= s4_h_q;
    s5_flags_q <= s4_flags_q;
  end

  // stage 6: quotient too large for the cells saturates the level
  logic [MaxW-1:0] upper_ext;
  logic            ovf_d;
  side2_t          side2_d;

  assign upper_ext     = MaxW'(s5_prod_q[Prod2W-1:LvlW]);
  assign ovf_d         = upper_ext >= MaxW'(rel_e);
  assign side2_d.base  = s5_h_q;
  assign side2_d.flags = s5_flags_q;
  assign side2_d.ovf   = ovf_d;

  logic            s6_valid_q;
  logic [LenW-1:0] s6_rem_q;
  logic [LvlW-1:0] s6_num_q;
  side2_t          s6_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else begin
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_rem_q  <= ovf_d ? '0 : upper_ext[LenW-1:0];
    s6_num_q  <= s5_prod_q[LvlW-1:0];
    s6_side_q <= side2_d;
  end

  logic              d2_valid;
  logic [LvlW-1:0]   d2_quo;
  logic [Side2W-1:0] d2_side_bits;
  side2_t            d2_side;

  adsr_div_chain #(
    .DW(LenW),
    .QW(LvlW),
    .SW(Side2W)
  ) u_div_release (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s6_valid_q),
    .rem_i  (s6_rem_q),
    .num_i  (s6_num_q),
    .den_i  (rel_e),
    .side_i (s6_side_q),
    .valid_o(d2_valid),
    .quo_o  (d2_quo),
    .side_o (d2_side_bits)
  );

  assign d2_side = side2_t'(d2_side_bits);

  // stage 7: final level
  logic [LvlW:0]   sum;
  logic [LvlW-1:0] lvl_d;

  assign sum = {1'b0, d2_side.base} + {1'b0, d2_quo};

  always_comb begin
    if (d2_side.flags.held) begin
      lvl_d = d2_side.base;
    end else if (d2_side.base == '0) begin
      lvl_d = '0;
    end else if (!d2_side.flags.rneg) begin
      lvl_d = d2_side.flags.rbig ? '0 : (d2_side.base - d2_quo);
    end else if (d2_side.ovf || (sum > {1'b0, One})) begin
      lvl_d = One;
    end else begin
      lvl_d = sum[LvlW-1:0];
    end
  end

  logic            done_q;
  logic [LvlW-1:0] level_q;
  logic            silent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q  <= lvl_d;
    silent_q <= (lvl_d == '0);
  end

  assign done_o   = done_q;
  assign level_o  = level_q;
  assign silent_o = silent_q;

endmodule
